// ===== rtl/core/mah_pkg.sv =====
// ----------------------------------------------------------------------------
// mah_pkg
// Shared types and constants of the moving-average high-pass filter.
// ----------------------------------------------------------------------------
package mah_pkg;

  // largest averaging window, forced odd
  localparam int unsigned MAX_WINDOW = 63;
  localparam logic [5:0]  MAX_WIN_ODD = 6'(MAX_WINDOW | 1);

  // history ring
  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned HIST_AW    = 6;

  // dividend bits of the rounding division
  localparam int unsigned DIV_W = 24;

  // register index of the window length
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_DRAIN,
    ST_NUM,
    ST_PREP,
    ST_DIV,
    ST_PUSH
  } state_t;

endpackage

// ===== rtl/core/moving_average_highpass.sv =====
// ----------------------------------------------------------------------------
// moving_average_highpass
// Sample minus centered moving average over an odd window, edges replicated.
// ----------------------------------------------------------------------------
// The output trails the input by half a window of samples. Each result pass
// reads 2*h+2 history terms (one memory read a cycle), then runs DRAIN, NUM,
// PREP, the divider and the push. A non-final sample runs at most one pass, a
// final one one per pending result (up to h+1). One input transaction at a time.
// Reset (synchronous, rst_n low) clears the control state and sets W to 1;
// the history memory is not cleared, each entry is written before it is read.
// ----------------------------------------------------------------------------
module moving_average_highpass (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic        in_tlast,   // end_of_stream
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,  // last_out
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mah_pkg::state_t state_r, state_nxt;

  logic [5:0]  wl_r;
  logic [6:0]  rc_r, em_r;
  logic [15:0] first_r, x_r;
  logic        eos_r;
  logic [5:0]  newest_r;
  logic [5:0]  d_r;
  logic [5:0]  left_r;
  logic [5:0]  t_r;
  logic signed [21:0] sum_r;
  logic signed [15:0] cx_r;
  logic signed [23:0] num_r;
  logic        neg_r;
  logic [mah_pkg::DIV_W-1:0] dvd_r;
  logic [7:0]  rem_r;
  logic [4:0]  dcnt_r;
  logic        p_vld_r, p_ctr_r, p_const_r;
  logic [15:0] p_val_r;
  logic        out_valid_r, out_last_r;
  logic [15:0] out_data_r;

  // history memory
  logic [15:0] hist_mem [mah_pkg::HIST_DEPTH];
  logic [15:0] mem_q;
  logic [mah_pkg::HIST_AW-1:0] rd_addr;

  // effective window and half width
  logic [5:0] win;
  logic [4:0] half;
  assign win  = (wl_r > mah_pkg::MAX_WIN_ODD) ? mah_pkg::MAX_WIN_ODD : wl_r;
  assign half = win[5:1];

  // configuration port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == mah_pkg::REG_WINDOW);
  assign cfg_prdata = (cfg_paddr[2] == mah_pkg::REG_WINDOW) ? {26'd0, wl_r} : 32'd0;

  assign in_tready  = (state_r == mah_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // term of the window sum for counter t_r (t_r == 0 fetches the center)
  logic signed [7:0] k_s;
  logic signed [8:0] pos_s, off_s;
  logic              below, past_new, last_term;
  assign k_s       = $signed({2'b00, t_r}) - 8'sd1 - $signed({3'b000, half});
  assign pos_s     = $signed({2'b00, em_r}) + 9'(k_s);
  assign off_s     = $signed({3'b000, d_r}) - 9'(k_s);
  assign below     = pos_s < 0;
  assign past_new  = off_s < 0;
  assign last_term = (t_r == {half, 1'b1});

  always_comb begin
    if (t_r == 6'd0) rd_addr = newest_r - d_r;
    else             rd_addr = newest_r - off_s[5:0];
  end

  // pending results after the current sample is stored
  logic [6:0] rc_inc, pending;
  assign rc_inc  = rc_r + 7'd1;
  assign pending = (em_r == 7'd0) ? rc_inc : {2'b00, half} + 7'd1;

  // divider step
  logic [7:0] remx, dv2;
  logic       ge;
  assign remx = {rem_r[6:0], dvd_r[mah_pkg::DIV_W-1]};
  assign dv2  = {1'b0, win, 1'b0};
  assign ge   = remx >= dv2;

  // saturated signed result
  logic [15:0] sat_q;
  always_comb begin
    if (neg_r) begin
      if (dvd_r > 24'd32768) sat_q = 16'h8000;
      else                   sat_q = 16'(~dvd_r + 24'd1);
    end else begin
      if (dvd_r > 24'd32767) sat_q = 16'h7FFF;
      else                   sat_q = dvd_r[15:0];
    end
  end

  logic push_ok;
  assign push_ok = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mah_pkg::ST_IDLE:  if (in_tvalid) state_nxt = mah_pkg::ST_WRITE;
      mah_pkg::ST_WRITE: begin
        if (eos_r || pending > {2'b00, half}) state_nxt = mah_pkg::ST_SUM;
        else                                  state_nxt = mah_pkg::ST_IDLE;
      end
      mah_pkg::ST_SUM:   if (last_term) state_nxt = mah_pkg::ST_DRAIN;
      mah_pkg::ST_DRAIN: state_nxt = mah_pkg::ST_NUM;
      mah_pkg::ST_NUM:   state_nxt = mah_pkg::ST_PREP;
      mah_pkg::ST_PREP:  state_nxt = mah_pkg::ST_DIV;
      mah_pkg::ST_DIV:   if (dcnt_r == 5'(mah_pkg::DIV_W - 1)) state_nxt = mah_pkg::ST_PUSH;
      mah_pkg::ST_PUSH: begin
        if (push_ok) begin
          if (left_r == 6'd1) state_nxt = mah_pkg::ST_IDLE;
          else                state_nxt = mah_pkg::ST_SUM;
        end
      end
      default: state_nxt = mah_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mah_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == mah_pkg::ST_WRITE) hist_mem[rc_r[5:0]] <= x_r;
    mem_q <= hist_mem[rd_addr];
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= 6'd1;
      rc_r        <= 7'd0;
      em_r        <= 7'd0;
      first_r     <= 16'd0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a push in the same cycle reloads the output register instead
      if (out_valid_r && out_tready && state_r != mah_pkg::ST_PUSH)
        out_valid_r <= 1'b0;
      if (cfg_wr) begin
        wl_r <= cfg_pwdata[5:0] | 6'd1;
        rc_r <= 7'd0;
        em_r <= 7'd0;
      end
      p_vld_r <= 1'b0;
      case (state_r)
        mah_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            x_r   <= in_tdata;
            eos_r <= in_tlast;
          end
        end
        mah_pkg::ST_WRITE: begin
          if (em_r == 7'd0 && rc_r == 7'd0) first_r <= x_r;
          newest_r <= rc_r[5:0];
          rc_r     <= rc_inc;
          t_r      <= 6'd0;
          if (eos_r) begin
            left_r <= pending[5:0];
            d_r    <= 6'(pending - 7'd1);
          end else begin
            left_r <= 6'd1;
            d_r    <= {1'b0, half};
          end
        end
        mah_pkg::ST_SUM: begin
          // issue one term a cycle, accumulate the one issued before
          p_vld_r   <= 1'b1;
          p_ctr_r   <= (t_r == 6'd0);
          p_const_r <= (t_r != 6'd0) && (below || past_new);
          p_val_r   <= below ? first_r : x_r;
          t_r       <= t_r + 6'd1;
          if (t_r == 6'd0) sum_r <= 22'sd0;
        end
        mah_pkg::ST_NUM: begin
          num_r <= 24'($signed({1'b0, win}) * cx_r) - 24'(sum_r);
        end
        mah_pkg::ST_PREP: begin
          neg_r  <= num_r[23];
          dvd_r  <= ((num_r[23] ? (~num_r + 24'd1) : num_r) << 1) + {18'd0, win};
          rem_r  <= 8'd0;
          dcnt_r <= 5'd0;
        end
        mah_pkg::ST_DIV: begin
          rem_r  <= ge ? (remx - dv2) : remx;
          dvd_r  <= {dvd_r[mah_pkg::DIV_W-2:0], ge};
          dcnt_r <= dcnt_r + 5'd1;
        end
        mah_pkg::ST_PUSH: begin
          if (push_ok) begin
            out_valid_r <= 1'b1;
            out_data_r  <= sat_q;
            out_last_r  <= eos_r && (left_r == 6'd1);
            left_r <= left_r - 6'd1;
            d_r    <= d_r - 6'd1;
            t_r    <= 6'd0;
            if (left_r == 6'd1 && eos_r) begin
              rc_r <= 7'd0;
              em_r <= 7'd0;
            end else if (em_r != 7'd127) begin
              em_r <= em_r + 7'd1;
            end
          end
        end
        default: ;
      endcase
      // accumulate the term fetched in the previous cycle
      if (p_vld_r) begin
        if (p_ctr_r)        cx_r  <= $signed(mem_q);
        else if (p_const_r) sum_r <= sum_r + 22'($signed(p_val_r));
        else                sum_r <= sum_r + 22'($signed(mem_q));
      end
    end
  end

  // assertions
  a_sum_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mah_pkg::ST_SUM && t_r == 6'd0) |-> !p_vld_r)
    else $error("term pipeline busy at start of window sum");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mah_pkg::ST_DIV) |=>
      (state_r == mah_pkg::ST_DIV || state_r == mah_pkg::ST_PUSH))
    else $error("divider left early");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && state_r == mah_pkg::ST_IDLE) |=> (rc_r == 7'd0 && em_r == 7'd0))
    else $error("window write did not restart stream");

  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mah_pkg::ST_DRAIN) |-> p_vld_r)
    else $error("last window term lost");

endmodule

// ===== tb/moving_average_highpass_tb.sv =====
// ----------------------------------------------------------------------------
// moving_average_highpass_tb
// Self-checking bench for the moving-average high-pass filter: drives sample
// streams and window writes with random gaps and stalls, predicts every
// filtered sample with its own ring and window sum, and compares each output
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module moving_average_highpass_tb;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE      = 300;
  localparam logic [2:0]  ADDR_WINDOW = 3'(int'(mah_pkg::REG_WINDOW) * 4);
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  moving_average_highpass dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter model state
  logic signed [15:0] ring [64];
  int unsigned        recv_cnt, emit_pos;
  logic signed [15:0] first_x;
  logic [5:0]         win_reg;

  // expected filtered samples, oldest first
  logic [15:0] hp_sample_q [$];
  logic        hp_last_q [$];

  int unsigned errors, cycles, items_sent, results_seen, streams_done;
  int unsigned idle_pct;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one filtered sample centered d places behind the newest entry
  function automatic logic [15:0] highpass(int newest, int d, int i, int h, int w);
    longint sum, num, q;
    int off;
    logic signed [15:0] v, x;
    sum = 0;
    x = ring[(newest + 64 - d) & 63];
    for (int k = -h; k <= h; k++) begin
      off = d - k;
      if (i + k < 0) v = first_x;
      else if (off < 0) v = ring[newest & 63];
      else v = ring[(newest + 64 - off) & 63];
      sum += v;
    end
    num = longint'(w) * x - sum;
    if (num >= 0) q = (2 * num + w) / (2 * w);
    else q = -((-2 * num + w) / (2 * w));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // advance the model by one accepted sample
  function automatic void predict_sample(logic signed [15:0] x, logic eos);
    int w, h, newest, pending;
    w = int'(win_reg | 6'd1);
    if (w > int'(mah_pkg::MAX_WIN_ODD)) w = int'(mah_pkg::MAX_WIN_ODD);
    h = w / 2;
    if (emit_pos == 0 && recv_cnt == 0) first_x = x;
    newest = recv_cnt & 63;
    ring[newest] = x;
    recv_cnt = (recv_cnt + 1) & 127;
    pending = (emit_pos == 0) ? int'(recv_cnt) : h + 1;
    if (!eos) begin
      if (pending > h) begin
        hp_sample_q.push_back(highpass(newest, h, emit_pos, h, w));
        hp_last_q.push_back(1'b0);
        if (emit_pos < 127) emit_pos++;
      end
      return;
    end
    // end of stream flushes everything held
    for (int j = 0; j < pending; j++) begin
      hp_sample_q.push_back(highpass(newest, pending - 1 - j, emit_pos, h, w));
      hp_last_q.push_back(j == pending - 1);
      if (emit_pos < 127) emit_pos++;
    end
    recv_cnt = 0;
    emit_pos = 0;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (hp_sample_q.size() == 0) begin
        $error("unexpected output transaction: sample_out=%0d last_out=%0b",
               $signed(out_tdata), out_tlast);
        errors++;
      end else begin
        if (out_tdata !== hp_sample_q[0]) begin
          $error("sample_out: expected %0d, got %0d",
                 $signed(hp_sample_q[0]), $signed(out_tdata));
          errors++;
        end
        if (out_tlast !== hp_last_q[0]) begin
          $error("last_out: expected %0b, got %0b", hp_last_q[0], out_tlast);
          errors++;
        end
        void'(hp_sample_q.pop_front());
        void'(hp_last_q.pop_front());
      end
    end
  end

  // result-side stalls
  always @(negedge clk) out_tready = ($urandom_range(99) >= idle_pct);

  task automatic send_sample(logic signed [15:0] x, logic eos);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = x;
    in_tlast  = eos;
    do @(posedge clk); while (!in_tready);
    predict_sample(x, eos);
    items_sent++;
    if (eos) streams_done++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (hp_sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, then read back
  task automatic write_window(logic [2:0] addr, logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = addr; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_WINDOW) begin
      win_reg = value[5:0] | 6'd1;
      recv_cnt = 0;
      emit_pos = 0;
    end
    @(negedge clk);
    cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = ADDR_WINDOW;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    if (rd[5:0] !== win_reg) begin
      $error("window_length readback: expected %0d, got %0d", win_reg, rd[5:0]);
      errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_stream(int len);
    for (int n = 0; n < len; n++) send_sample(pick_sample(), n == len - 1);
  endtask

  // extremes, single-sample stream, edge replication
  task automatic test_directed();
    write_window(ADDR_WINDOW, 32'd0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h1234, 1'b1);
    wait_idle();
    write_window(ADDR_WINDOW, 32'd62);  // even write, forced odd
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);        // short stream
    wait_idle();
    write_window(ADDR_WINDOW, 32'd3);
    for (int n = 0; n < 8; n++) send_sample(n[0] ? 16'h7FFF : 16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    wait_idle();
  endtask

  // ignored-write address and mid-stream window write
  task automatic test_config_cases();
    write_window(ADDR_UNUSED, 32'd9);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h0200, 1'b1);
    wait_idle();
    write_window(ADDR_WINDOW, 32'd7);
    send_stream(2);
    for (int n = 0; n < 5; n++) send_sample(pick_sample(), 1'b0);
    wait_idle();
    write_window(ADDR_WINDOW, 32'd5);   // drops held samples
    send_stream(6);
    wait_idle();
  endtask

  // long stream wraps the ring and the receive counter, saturates the emit counter
  task automatic test_long_stream();
    write_window(ADDR_WINDOW, 32'd63);
    send_stream(140);
    wait_idle();
  endtask

  task automatic test_random();
    logic [5:0] w;
    int len, budget;
    budget = 280;
    while (budget > 0) begin
      case ($urandom_range(5))
        0: w = 6'd1;
        1: w = 6'd63;
        2: w = 6'($urandom_range(63));
        default: w = 6'($urandom_range(15));
      endcase
      write_window(ADDR_WINDOW, {$urandom} & 32'hFFFF_FFC0 | w);
      for (int s = 0; s < 3 && budget > 0; s++) begin
        len = ($urandom_range(4) == 0) ? int'($urandom_range(8)) + 1
                                       : int'($urandom_range(40)) + 1;
        send_stream(len);
        budget -= len;
      end
      // quiet stretch with no gaps or stalls
      idle_pct = (budget > 80 && budget < 180) ? 0 : 14;
      wait_idle();
    end
  endtask

  initial begin
    idle_pct = 14;
    win_reg  = 6'd1;
    recv_cnt = 0;
    emit_pos = 0;
    first_x  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_cases();
    test_long_stream();
    test_random();
    $display("Sent %0d samples in %0d streams, checked %0d filtered samples,",
             items_sent, streams_done, results_seen);
    $display("window lengths from 1 to 63, register writes and readback included.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
